[hw/rtl/ibm_pkg.sv]
// ----------------------------------------------------------------------------
// ibm_pkg
// Shared types and codes for the bus monitor: line samples, the events that
// pass between the front and back, and the output records.
// ----------------------------------------------------------------------------
package ibm_pkg;

  // One sample of the two bus lines
  typedef struct packed {
    logic scl;
    logic sda;
  } sample_t;

  // Record kinds
  localparam logic [1:0] KIND_ADDR = 2'd0;
  localparam logic [1:0] KIND_DATA = 2'd1;
  localparam logic [1:0] KIND_STOP = 2'd2;

  // One monitor record
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] byte_value;
    logic       nack;
    logic [6:0] target_address;
    logic       is_read;
    logic [7:0] byte_index;
    logic       overflow;
  } record_t;

  // Bus event codes from the front
  localparam logic [1:0] EV_START = 2'd0;
  localparam logic [1:0] EV_STOP  = 2'd1;
  localparam logic [1:0] EV_RISE  = 2'd2;

  // Event handed from front to back
  typedef struct packed {
    logic [1:0] code;
    logic       sda;
  } event_t;

  // Bits per byte and the event queue depth and address width
  localparam logic [3:0] BITS_PER_BYTE = 4'd8;
  localparam int         EVQ_DEPTH     = 2;
  localparam int         EVQ_AW        = $clog2(EVQ_DEPTH);

  // Configuration register indexes
  localparam logic CFG_MAX_BYTES = 1'b0;
  localparam logic CFG_PAUSED    = 1'b1;

  // Reset value of max_bytes
  localparam logic [7:0] MAX_BYTES_RESET = 8'd32;

endpackage

[hw/rtl/ibm_front.sv]
// ----------------------------------------------------------------------------
// ibm_front
// Tracks the previous line levels and turns each accepted sample into at most
// one bus event (START, STOP or SCL rise) for the back end.
// ----------------------------------------------------------------------------
module ibm_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  ibm_pkg::sample_t sample,
  input  logic             paused,
  output logic             ev_push,
  output ibm_pkg::event_t  ev
);
  import ibm_pkg::*;

  logic prev_scl;
  logic prev_sda;
  logic scl_rise;
  logic sda_change;

  // Edge detection against the previous sample
  assign scl_rise   = !prev_scl && sample.scl;
  assign sda_change = sample.sda != prev_sda;

  // Classification: an SCL rise wins over an SDA change in the same sample
  always_comb begin
    ev_push = 1'b0;
    ev.code = EV_RISE;
    ev.sda  = sample.sda;
    priority if (scl_rise) begin
      ev_push = accept && !paused;
    end else if (sda_change && sample.scl) begin
      ev_push = accept && !paused;
      ev.code = sample.sda ? EV_STOP : EV_START;
    end else begin
      // no bus event in this sample
    end
  end

  // Line levels follow every accepted sample, paused or not
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_scl <= 1'b1;
      prev_sda <= 1'b1;
    end else if (accept) begin
      prev_scl <= sample.scl;
      prev_sda <= sample.sda;
    end
  end

endmodule

[hw/rtl/ibm_evq.sv]
// ----------------------------------------------------------------------------
// ibm_evq
// Small event queue between the front and back so each side stalls alone.
// ----------------------------------------------------------------------------
module ibm_evq (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  ibm_pkg::event_t push_ev,
  output logic            full,
  input  logic            pop,
  output logic            ev_valid,
  output ibm_pkg::event_t pop_ev
);
  import ibm_pkg::*;

  event_t            entries [EVQ_DEPTH];
  logic [EVQ_AW-1:0] wr_ptr;
  logic [EVQ_AW-1:0] rd_ptr;
  logic [EVQ_AW:0]   count;
  logic [EVQ_AW:0]   count_next;

  assign full     = count == (EVQ_AW+1)'(EVQ_DEPTH);
  assign ev_valid = count != '0;
  assign pop_ev   = entries[rd_ptr];

  // Occupancy
  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 1'b1;
    end else if (pop && !push) begin
      count_next = count - 1'b1;
    end
  end

  // Pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= (wr_ptr == EVQ_AW'(EVQ_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == EVQ_AW'(EVQ_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_ev;
    end
  end

endmodule

[hw/rtl/ibm_back.sv]
// ----------------------------------------------------------------------------
// ibm_back
// Transaction tracker: shifts in bits, takes the ack, keeps address and
// counters, and loads finished records into the output register.
// ----------------------------------------------------------------------------
module ibm_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             ev_valid,
  input  ibm_pkg::event_t  ev,
  output logic             pop,
  input  logic [7:0]       max_bytes,
  output logic             record_valid,
  input  logic             record_ready,
  output ibm_pkg::record_t record
);
  import ibm_pkg::*;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_DATA = 2'd1;
  localparam logic [1:0] PH_ACK  = 2'd2;

  logic [1:0] phase,        phase_next;
  logic [3:0] bit_count,    bit_count_next;
  logic [7:0] shift_byte,   shift_byte_next;
  logic       address_seen, address_seen_next;
  logic [6:0] held_address, held_address_next;
  logic       held_read,    held_read_next;
  logic [7:0] data_count,   data_count_next;
  logic       last_nack,    last_nack_next;
  logic       dropped_flag, dropped_flag_next;
  logic       emit;
  record_t    rec;
  logic       slot_free;

  // Take an event whenever the output slot is free or being drained
  assign slot_free = !record_valid || record_ready;
  assign pop       = ev_valid && slot_free;

  // Event handling
  always_comb begin
    phase_next        = phase;
    bit_count_next    = bit_count;
    shift_byte_next   = shift_byte;
    address_seen_next = address_seen;
    held_address_next = held_address;
    held_read_next    = held_read;
    data_count_next   = data_count;
    last_nack_next    = last_nack;
    dropped_flag_next = dropped_flag;
    emit              = 1'b0;
    rec               = '0;
    rec.target_address = held_address;
    rec.is_read        = held_read;
    unique case (ev.code)
      EV_START: begin
        phase_next        = PH_DATA;
        bit_count_next    = '0;
        shift_byte_next   = '0;
        address_seen_next = 1'b0;
        held_address_next = '0;
        held_read_next    = 1'b0;
        data_count_next   = '0;
        last_nack_next    = 1'b0;
        dropped_flag_next = 1'b0;
      end
      EV_STOP: begin
        if (phase != PH_IDLE) begin
          emit           = 1'b1;
          rec.kind       = KIND_STOP;
          rec.nack       = last_nack;
          rec.byte_index = data_count;
          rec.overflow   = dropped_flag;
          phase_next     = PH_IDLE;
        end
      end
      EV_RISE: begin
        if (phase == PH_DATA) begin
          shift_byte_next = {shift_byte[6:0], ev.sda};
          bit_count_next  = bit_count + 1'b1;
          if (bit_count_next >= BITS_PER_BYTE) begin
            phase_next = PH_ACK;
          end
        end else if (phase == PH_ACK) begin
          last_nack_next = ev.sda;
          rec.byte_value = shift_byte;
          rec.nack       = ev.sda;
          if (!address_seen) begin
            // First byte of a transaction: address plus direction
            held_address_next  = shift_byte[7:1];
            held_read_next     = shift_byte[0];
            address_seen_next  = 1'b1;
            emit               = 1'b1;
            rec.kind           = KIND_ADDR;
            rec.target_address = shift_byte[7:1];
            rec.is_read        = shift_byte[0];
          end else if (data_count < max_bytes) begin
            emit            = 1'b1;
            rec.kind        = KIND_DATA;
            rec.byte_index  = data_count;
            data_count_next = data_count + 1'b1;
          end else begin
            dropped_flag_next = 1'b1;
          end
          phase_next      = PH_DATA;
          bit_count_next  = '0;
          shift_byte_next = '0;
        end
      end
      default: begin
      end
    endcase
  end

  // Transaction state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      bit_count    <= '0;
      shift_byte   <= '0;
      address_seen <= 1'b0;
      held_address <= '0;
      held_read    <= 1'b0;
      data_count   <= '0;
      last_nack    <= 1'b0;
      dropped_flag <= 1'b0;
    end else if (pop) begin
      phase        <= phase_next;
      bit_count    <= bit_count_next;
      shift_byte   <= shift_byte_next;
      address_seen <= address_seen_next;
      held_address <= held_address_next;
      held_read    <= held_read_next;
      data_count   <= data_count_next;
      last_nack    <= last_nack_next;
      dropped_flag <= dropped_flag_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      record_valid <= 1'b0;
    end else if (slot_free) begin
      record_valid <= pop && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      record <= rec;
    end
  end

endmodule

[hw/rtl/i2c_bus_monitor_unit.sv]
// ----------------------------------------------------------------------------
// i2c_bus_monitor_unit
// Passive two-wire bus monitor: classifies line samples into bus events and
// reports a record per address or kept byte, and a summary per closing STOP.
//
//   Channel   Handshake                       Payload
//   sample    sample_valid / sample_ready     sample (scl, sda)
//   record    record_valid / record_ready     record (byte / stop summary)
//   config    cfg_we (no wait)                cfg_index, cfg_data
//
// One sample is taken per cycle while sample_ready is high; a record reaches
// the output through the event queue, then the output register.
// The back end handles one event per cycle while its output slot is free.
// Reset is synchronous; no clearing pass.
// A stalled record output fills the two-entry event queue, then the front
// drops sample_ready.
// ----------------------------------------------------------------------------
module i2c_bus_monitor_unit (
  input  logic             clk,
  input  logic             rst,
  input  logic             sample_valid,
  output logic             sample_ready,
  input  ibm_pkg::sample_t sample,
  output logic             record_valid,
  input  logic             record_ready,
  output ibm_pkg::record_t record,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [7:0]       cfg_data
);
  import ibm_pkg::*;

  logic       accept;
  logic       q_full;
  logic       ev_push;
  event_t     push_ev;
  logic       ev_valid;
  event_t     pop_ev;
  logic       ev_pop;
  logic [7:0] max_bytes;
  logic       paused;

  assign sample_ready = !q_full;
  assign accept       = sample_valid && sample_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      max_bytes <= MAX_BYTES_RESET;
      paused    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAX_BYTES: max_bytes <= cfg_data;
        CFG_PAUSED:    paused    <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  ibm_front u_front (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .sample  (sample),
    .paused  (paused),
    .ev_push (ev_push),
    .ev      (push_ev)
  );

  ibm_evq u_evq (
    .clk      (clk),
    .rst      (rst),
    .push     (ev_push),
    .push_ev  (push_ev),
    .full     (q_full),
    .pop      (ev_pop),
    .ev_valid (ev_valid),
    .pop_ev   (pop_ev)
  );

  ibm_back u_back (
    .clk          (clk),
    .rst          (rst),
    .ev_valid     (ev_valid),
    .ev           (pop_ev),
    .pop          (ev_pop),
    .max_bytes    (max_bytes),
    .record_valid (record_valid),
    .record_ready (record_ready),
    .record       (record)
  );

  // Front only stalls while events are waiting
  a_stall_has_events: assert property (@(posedge clk) disable iff (rst)
    !sample_ready |-> ev_valid)
    else $error("sample_ready low with empty event queue");

  // Paused samples produce no events
  a_paused_quiet: assert property (@(posedge clk) disable iff (rst)
    (accept && paused) |-> !ev_push)
    else $error("event pushed while paused");

  // Only stop summaries carry the overflow flag
  a_overflow_stop_only: assert property (@(posedge clk) disable iff (rst)
    (record_valid && record.kind != KIND_STOP) |-> !record.overflow)
    else $error("overflow set on a byte record");

  // No record right after reset
  a_reset_clears: assert property (@(posedge clk)
    rst |=> !record_valid)
    else $error("record valid after reset");

endmodule

[test/tb_i2c_bus_monitor_unit.sv]
// ----------------------------------------------------------------------------
// tb_i2c_bus_monitor_unit
// Self-checking bench for the two-wire bus monitor. Builds SCL/SDA sample
// streams (well-formed transactions, repeated starts, broken bytes, skewed
// edges, noise), drives them through the sample channel in random bursts,
// predicts every record with a cycle-free model of the monitor, and checks
// each record from the output channel field by field against the oldest
// prediction. Configuration changes only while the monitor is idle.
// ----------------------------------------------------------------------------
module tb_i2c_bus_monitor_unit;
  import ibm_pkg::*;

  typedef enum logic [1:0] {BUS_IDLE, BUS_BITS, BUS_ACK} bus_phase_t;

  logic       clk;
  logic       rst = 1'b1;
  logic       sample_valid = 1'b0;
  logic       sample_ready;
  sample_t    sample = '0;
  logic       record_valid;
  logic       record_ready = 1'b0;
  record_t    record;
  logic       cfg_we = 1'b0;
  logic       cfg_index = CFG_MAX_BYTES;
  logic [7:0] cfg_data = '0;

  i2c_bus_monitor_unit dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .record_valid (record_valid),
    .record_ready (record_ready),
    .record       (record),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // Line samples waiting to go out, and records the model says must come back
  sample_t line_q[$];
  record_t due_records[$];

  // Monitor model: configuration copy and bus tracking state
  logic [7:0] lim_bytes = MAX_BYTES_RESET;
  logic       pause_on = 1'b0;
  logic       ln_scl = 1'b1;
  logic       ln_sda = 1'b1;
  bus_phase_t bus_phs = BUS_IDLE;
  logic [3:0] nbits = '0;
  logic [7:0] shreg = '0;
  logic       addr_done = 1'b0;
  logic [6:0] cur_addr = '0;
  logic       cur_rd = 1'b0;
  logic [7:0] kept = '0;
  logic       nack_hold = 1'b0;
  logic       drop_seen = 1'b0;

  // Stimulus generator state and knobs
  logic g_scl = 1'b1;
  logic g_sda = 1'b1;
  int   gen_samples = 0;
  int   gen_bytes = 0;
  int   skew_pct = 0;
  int   stretch_pct = 0;
  int   gap_max = 0;
  int   stall_pct = 0;

  // Driver / receiver / checker bookkeeping
  logic sample_taken = 1'b0;
  int   gap_left = 0;
  int   burst_left = 0;
  int   hold_left = 0;
  int   hold_mark = 0;
  int   holds = 0;
  int   n_samples = 0;
  int   n_recs = 0;
  int   n_addr = 0;
  int   n_data = 0;
  int   n_stop = 0;
  int   n_dropped = 0;
  int   fails = 0;

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Run limit
  initial begin
    #1000000;
    $display("i2c_bus_monitor_unit test failed");
    $finish;
  end

  // Model of the monitor for one accepted line sample
  function automatic void track_bus(sample_t s);
    logic    rise;
    logic    chg;
    record_t r;
    rise = !ln_scl && s.scl;
    chg  = (s.sda != ln_sda);
    r    = '0;
    if (!pause_on) begin
      if (rise) begin
        if (bus_phs == BUS_BITS) begin
          shreg = {shreg[6:0], s.sda};
          nbits = nbits + 4'd1;
          if (nbits >= BITS_PER_BYTE) bus_phs = BUS_ACK;
        end else if (bus_phs == BUS_ACK) begin
          nack_hold    = s.sda;
          r.byte_value = shreg;
          r.nack       = s.sda;
          if (!addr_done) begin
            cur_addr  = shreg[7:1];
            cur_rd    = shreg[0];
            addr_done = 1'b1;
            r.kind           = KIND_ADDR;
            r.target_address = cur_addr;
            r.is_read        = cur_rd;
            due_records.push_back(r);
          end else if (kept < lim_bytes) begin
            r.kind           = KIND_DATA;
            r.target_address = cur_addr;
            r.is_read        = cur_rd;
            r.byte_index     = kept;
            kept             = kept + 8'd1;
            due_records.push_back(r);
          end else begin
            drop_seen = 1'b1;
            n_dropped++;
          end
          bus_phs = BUS_BITS;
          nbits   = '0;
          shreg   = '0;
        end
      end else if (chg && s.scl) begin
        if (!s.sda) begin
          // START or repeated START: fresh transaction
          bus_phs   = BUS_BITS;
          nbits     = '0;
          shreg     = '0;
          addr_done = 1'b0;
          cur_addr  = '0;
          cur_rd    = 1'b0;
          kept      = '0;
          nack_hold = 1'b0;
          drop_seen = 1'b0;
        end else if (bus_phs != BUS_IDLE) begin
          r.kind           = KIND_STOP;
          r.nack           = nack_hold;
          r.target_address = cur_addr;
          r.is_read        = cur_rd;
          r.byte_index     = kept;
          r.overflow       = drop_seen;
          due_records.push_back(r);
          bus_phs = BUS_IDLE;
        end
      end
    end
    ln_scl = s.scl;
    ln_sda = s.sda;
  endfunction

  // Sample channel driver: bursts of requests with random gaps
  always @(negedge clk) begin
    if (!rst && (!sample_valid || sample_taken)) begin
      if (gap_left > 0) begin
        gap_left--;
        sample_valid <= 1'b0;
      end else if (line_q.size() > 0) begin
        sample       <= line_q.pop_front();
        sample_valid <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, gap_max);
        end
      end else begin
        sample_valid <= 1'b0;
      end
    end
  end

  // Record receiver: random stalls, plus long hold-offs while samples pile up
  always @(negedge clk) begin
    if (rst) begin
      record_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      record_ready <= 1'b0;
    end else if (line_q.size() > 150 && n_recs >= hold_mark) begin
      hold_left = 300;
      hold_mark = n_recs + 100;
      holds++;
      record_ready <= 1'b0;
    end else begin
      record_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Accept samples into the model, check records against predictions
  always @(posedge clk) begin
    record_t want;
    if (rst) begin
      sample_taken <= 1'b0;
    end else begin
      sample_taken <= sample_valid && sample_ready;
      if (sample_valid && sample_ready) begin
        track_bus(sample);
        n_samples++;
      end
      if (record_valid && record_ready) begin
        n_recs++;
        case (record.kind)
          KIND_ADDR: n_addr++;
          KIND_DATA: n_data++;
          default:   n_stop++;
        endcase
        if (due_records.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("unexpected record: kind %0d byte %02h nack %0d addr %02h rd %0d idx %0d ovf %0d",
                     record.kind, record.byte_value, record.nack, record.target_address,
                     record.is_read, record.byte_index, record.overflow);
        end else begin
          want = due_records.pop_front();
          if (record.kind !== want.kind || record.byte_value !== want.byte_value ||
              record.nack !== want.nack || record.target_address !== want.target_address ||
              record.is_read !== want.is_read || record.byte_index !== want.byte_index ||
              record.overflow !== want.overflow) begin
            fails++;
            if (fails <= 10) begin
              $display("record mismatch at %0t", $realtime);
              $display("  expected kind %0d byte %02h nack %0d addr %02h rd %0d idx %0d ovf %0d",
                       want.kind, want.byte_value, want.nack, want.target_address,
                       want.is_read, want.byte_index, want.overflow);
              $display("  actual   kind %0d byte %02h nack %0d addr %02h rd %0d idx %0d ovf %0d",
                       record.kind, record.byte_value, record.nack, record.target_address,
                       record.is_read, record.byte_index, record.overflow);
            end
          end
        end
      end
    end
  end

  // Queue one line sample
  task automatic put(input logic c, input logic d);
    sample_t s;
    s.scl = c;
    s.sda = d;
    line_q.push_back(s);
    g_scl = c;
    g_sda = d;
    gen_samples++;
  endtask

  // START from any line state; leaves SCL low
  task automatic bus_start();
    if (!(g_scl && g_sda)) begin
      if (g_scl) put(1'b0, g_sda);
      put(1'b0, 1'b1);
      put(1'b1, 1'b1);
    end
    put(1'b1, 1'b0);
    put(1'b0, 1'b0);
  endtask

  // STOP from any line state
  task automatic bus_stop();
    if (g_scl) put(1'b0, g_sda);
    put(1'b0, 1'b0);
    put(1'b1, 1'b0);
    put(1'b1, 1'b1);
  endtask

  // One clock bit; ends with SCL high. May flip SDA on the rise or stretch SCL.
  task automatic send_bit(input logic b);
    if ($urandom_range(0, 99) < skew_pct) begin
      put(1'b0, ~b);
      put(1'b1, b);
    end else begin
      put(1'b0, b);
      if ($urandom_range(0, 99) < stretch_pct) put(1'b0, b);
      put(1'b1, b);
    end
    if ($urandom_range(0, 99) < stretch_pct) put(1'b1, b);
  endtask

  // Low cnt bits of v, MSB first
  task automatic send_bits(input logic [7:0] v, input int cnt);
    for (int i = cnt - 1; i >= 0; i--) send_bit(v[i]);
  endtask

  // Full byte plus ack bit; leaves SCL low
  task automatic send_byte(input logic [7:0] v, input logic nk);
    send_bits(v, 8);
    send_bit(nk);
    put(1'b0, nk);
    gen_bytes++;
  endtask

  // One random bus episode: mostly well-formed transactions
  task automatic gen_transaction();
    int pick;
    int nd;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      // line noise
      repeat ($urandom_range(1, 8)) put(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end else if (pick < 14) begin
      // byte cut short by STOP
      bus_start();
      send_bits(8'($urandom_range(0, 255)), $urandom_range(1, 8));
      bus_stop();
    end else begin
      bus_start();
      send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
      nd = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 12) : $urandom_range(0, 4);
      repeat (nd) send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 5) == 0);
      if ($urandom_range(0, 4) == 0) begin
        bus_start();
        send_byte(8'($urandom_range(0, 255)), 1'b0);
        repeat ($urandom_range(0, 2))
          send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end
      if ($urandom_range(0, 9) != 0) bus_stop();
    end
  endtask

  // Let everything drain, then allow for samples still inside the block
  task automatic wait_idle();
    while (line_q.size() != 0 || sample_valid || due_records.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Write both registers while idle and mirror them in the model
  task automatic set_config(input logic [7:0] mb, input logic pz);
    wait_idle();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MAX_BYTES;
    cfg_data  <= mb;
    @(negedge clk);
    cfg_index <= CFG_PAUSED;
    cfg_data  <= {7'd0, pz};
    @(negedge clk);
    cfg_we    <= 1'b0;
    lim_bytes = mb;
    pause_on  = pz;
  endtask

  // Main sequence
  initial begin
    int rnd_start;
    int byte_start;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: defaults, no gaps or random stalls
    set_config(MAX_BYTES_RESET, 1'b0);
    put(1'b0, 1'b1); put(1'b1, 1'b1);                       // clock rise on idle bus
    put(1'b0, 1'b0); put(1'b1, 1'b0); put(1'b1, 1'b1);      // STOP with no transaction
    bus_start();
    send_byte(8'hA1, 1'b0); send_byte(8'h00, 1'b0); send_byte(8'hFF, 1'b1);
    bus_stop();
    bus_start(); send_byte(8'h00, 1'b1); bus_stop();
    bus_start();
    send_byte(8'hFE, 1'b0); send_byte(8'h5A, 1'b0);
    bus_start();                                            // repeated START
    send_byte(8'h3D, 1'b0); send_byte(8'hC3, 1'b1);
    bus_stop();
    // SDA changes on the same sample as the SCL rise: bits, not START/STOP
    bus_start();
    put(1'b0, 1'b1); put(1'b1, 1'b0); put(1'b0, 1'b0); put(1'b1, 1'b1);
    send_bits(8'h2C, 6); send_bit(1'b0); put(1'b0, 1'b0);
    bus_stop();
    bus_start(); send_bits(8'h55, 5); bus_stop();           // STOP inside a byte

    // Byte limit of one: later data dropped
    gap_max = 3; stall_pct = 30;
    set_config(8'd1, 1'b0);
    repeat (2) begin
      bus_start();
      send_byte(8'($urandom_range(0, 255)), 1'b0);
      repeat (3) send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      bus_stop();
    end

    // Byte limit of zero: no data kept at all
    set_config(8'd0, 1'b0);
    bus_start(); send_byte(8'h91, 1'b0); send_byte(8'h7E, 1'b0); send_byte(8'h81, 1'b1);
    bus_stop();

    // Paused: line levels tracked, no events
    set_config(8'd4, 1'b1);
    repeat (3) gen_transaction();
    bus_start(); send_bits(8'hB3, 4);
    set_config(8'd4, 1'b0);
    send_bits(8'h0F, 4); send_bit(1'b0); put(1'b0, 1'b0);
    send_byte(8'h42, 1'b0); bus_stop();

    // Largest limit, a few data bytes kept
    gap_max = 0; stall_pct = 0;
    set_config(8'd255, 1'b0);
    bus_start();
    send_byte(8'h50, 1'b0);
    repeat (5) send_byte(8'($urandom_range(0, 255)), 1'b0);
    bus_stop();

    // Random part: several settings, mostly small limits
    rnd_start  = gen_samples;
    byte_start = gen_bytes;
    while (gen_samples - rnd_start < 400 || gen_bytes - byte_start < 20) begin
      gap_max     = $urandom_range(0, 8);
      stall_pct   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 70);
      skew_pct    = $urandom_range(0, 8);
      stretch_pct = $urandom_range(0, 20);
      set_config(8'(($urandom_range(0, 3) == 0) ? $urandom_range(1, 255)
                                                 : $urandom_range(1, 6)),
                 $urandom_range(0, 5) == 0);
      repeat (4) gen_transaction();
    end

    wait_idle();
    $display("Covered %0d bus samples, %0d records (%0d address, %0d data, %0d stop); %0d data bytes dropped.",
             n_samples, n_recs, n_addr, n_data, n_stop, n_dropped);
    $display("Receiver held off %0d times; %0d failures.", holds, fails);
    if (fails == 0 && due_records.size() == 0) begin
      $display("i2c_bus_monitor_unit test passed");
    end else begin
      $display("i2c_bus_monitor_unit test failed");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/ibm_pkg.sv
hw/rtl/ibm_front.sv
hw/rtl/ibm_evq.sv
hw/rtl/ibm_back.sv
hw/rtl/i2c_bus_monitor_unit.sv
test/tb_i2c_bus_monitor_unit.sv
